/* src/psg_pkg.sv */
// psg_pkg: shared types, codes and constants of the pulse sequencer gate
// no dependencies; used by pulse_sequencer_gate_top
package psg_pkg;

  // default sizing
  localparam int MAX_EVENTS_DEF    = 16;
  localparam int DURATION_BITS_DEF = 8;

  // fixed field widths
  localparam int PULSE_W       = 16;
  localparam int SLOT_W        = 4;
  localparam int NOTE_W        = 6;
  localparam int OCT_W         = 4;
  localparam int DUR_IN_W      = 8;
  localparam int EVENT_INDEX_W = 4;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 5;
  localparam int COUNT_W       = 5;
  localparam int ARTIC_W       = 2;

  // release point as a fraction of the event span
  localparam int NORM_MUL = 9;
  localparam int NORM_DIV = 10;
  localparam int STAC_MUL = 55;
  localparam int STAC_DIV = 100;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PULSE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_EVENT_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARTIC       = 1'b1;

  // articulation codes
  localparam logic [ARTIC_W-1:0] ART_NORMAL   = 2'd0;
  localparam logic [ARTIC_W-1:0] ART_STACCATO = 2'd1;
  localparam logic [ARTIC_W-1:0] ART_LEGATO   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MOD,
    S_FIND,
    S_EVAL,
    S_OUT
  } state_t;

endpackage

/* src/psg_ram.sv */
// psg_ram: generic single-port-write, single-port-read RAM, registered read
// no dependencies
module psg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/psg_div.sv */
// psg_div: iterative restoring divider, one quotient bit per cycle
// depends on nothing; used for the loop modulo
module psg_div #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  assign shifted = {rem, quot[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign done    = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      quot <= dividend;
      rem  <= '0;
    end else if (busy && (cnt != '0)) begin
      if (!diff[DVS_W]) begin
        rem  <= diff[DVS_W-1:0];
        quot <= {quot[DVD_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[DVS_W-1:0];
        quot <= {quot[DVD_W-2:0], 1'b0};
      end
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("divider still busy after done");
  a_rem_range: assert property (@(posedge clk) disable iff (rst) done |-> rem < dvs)
    else $error("remainder not below divisor");
`endif

endmodule

/* src/pulse_sequencer_gate_top.sv */
// pulse_sequencer_gate_top: gate generator over a looping table of note events
// depends on psg_pkg, psg_ram (event table) and psg_div (loop modulo divider)
//
// usage:
//   item channel (item_valid / item_stall): one beat is a load or a pulse.
//     a load writes one event into the table and returns one result beat
//     with all event fields zero and the unchanged gate.
//     a pulse reduces the pulse number modulo the loop total, finds the
//     covering event and the event of the previous pulse, and returns one
//     result beat with the event fields, rise/fall edges and the new gate.
//   result channel (result_valid / result_stall): one beat per item.
//   config channel (cfg_valid / cfg_ready): event_count and articulation,
//     always ready. they are to be written only while the block is idle;
//     the block itself does not enforce this. a load goes straight to its
//     result beat. a pulse runs a walk that sums the live event durations,
//     one divider pass, a walk that finds the events and an evaluation
//     step. an empty loop skips the divider, the second walk and the evaluation.
//   one item is worked on at a time; item_stall is high until its result
//     sits in the output register. a stalled result holds; the next item
//     is taken while it waits, and its result waits until the beat leaves.
//   reset: gate low, config and control registers cleared, no result
//     pending. the table memory is not cleared and must be loaded before use.
module pulse_sequencer_gate_top #(
  parameter int MAX_EVENTS    = psg_pkg::MAX_EVENTS_DEF,
  parameter int DURATION_BITS = psg_pkg::DURATION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // config channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [psg_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [psg_pkg::CFG_DATA_W-1:0]         cfg_data,
  // item channel
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   req_type,
  input  logic [psg_pkg::PULSE_W-1:0]            pulse,
  input  logic [psg_pkg::SLOT_W-1:0]             slot,
  input  logic [psg_pkg::NOTE_W-1:0]             note_value,
  input  logic signed [psg_pkg::OCT_W-1:0]       octave_shift,
  input  logic                                   rest_flag,
  input  logic [psg_pkg::DUR_IN_W-1:0]           duration,
  // result channel
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic                                   event_found,
  output logic [psg_pkg::EVENT_INDEX_W-1:0]      event_index,
  output logic [psg_pkg::NOTE_W-1:0]             cur_note,
  output logic signed [psg_pkg::OCT_W-1:0]       cur_octave,
  output logic                                   cur_rest,
  output logic                                   rise_edge,
  output logic                                   fall_edge,
  output logic                                   gate_level
);

  import psg_pkg::*;

  localparam int DB     = DURATION_BITS;
  localparam int IDX_W  = MAX_EVENTS > 1 ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_EVENTS + 1);
  localparam int TOT_W  = DB + CNT_W;
  localparam int DVD_W  = PULSE_W;
  localparam int DVS_W  = TOT_W;
  localparam int MUL_W  = TOT_W + 7;
  localparam int ENT_W  = DB + NOTE_W + OCT_W + 1;

  // event entry layout: {note, octave, rest, duration}
  localparam int REST_B = DB;
  localparam int OCT_LO = DB + 1;
  localparam int NOTE_LO = DB + 1 + OCT_W;

  state_t state, state_next;

  // configuration
  logic [COUNT_W-1:0] event_count;
  logic [ARTIC_W-1:0] articulation;
  logic [CNT_W-1:0]   n_live;

  // table walk
  logic [CNT_W-1:0] cnt;
  logic             rvalid;
  logic [IDX_W-1:0] ridx;
  logic [TOT_W-1:0] acc;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] reach;
  logic             walking;
  logic             rd_en;
  logic             walk_done;
  logic [ENT_W-1:0] rdata;
  logic [DB-1:0]    rd_dur;

  // item context
  logic [PULSE_W-1:0] pulse_reg;
  logic               is_load;
  logic               found;
  logic [TOT_W-1:0]   np;
  logic [TOT_W-1:0]   pp;
  logic               cur_hit;
  logic               prv_hit;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W-1:0]   prv_idx;
  logic               prv_rest;
  logic [NOTE_W-1:0]  c_note;
  logic [OCT_W-1:0]   c_oct;
  logic               c_rest;
  logic [DB-1:0]      c_dur;
  logic               rise;
  logic               fall;
  logic               gate;
  logic               gate_next;

  // release evaluation
  logic             ev_rest_fall;
  logic             ev_sounding;
  logic             ev_short;
  logic             rel_hit;
  logic [TOT_W-1:0] off;
  logic [MUL_W-1:0] span_x;
  logic [MUL_W-1:0] rel_lo;
  logic [MUL_W-1:0] rel_hi;

  // divider
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DVD_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;

  // handshakes
  logic item_take;
  logic out_free;
  logic out_fire;
  logic load_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count  <= '0;
      articulation <= ART_NORMAL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EVENT_COUNT: event_count  <= cfg_data;
        CFG_ARTIC:       articulation <= cfg_data[ARTIC_W-1:0];
        default:         ;
      endcase
    end
  end

  // counts above the table size saturate
  assign n_live = (32'(event_count) > 32'(MAX_EVENTS)) ? CNT_W'(MAX_EVENTS)
                                                       : CNT_W'(event_count);

  // table memory
  assign load_we = item_take && (req_type == REQ_LOAD) && (32'(slot) < 32'(MAX_EVENTS));

  psg_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_EVENTS)
  ) u_table (
    .clk  (clk),
    .we   (load_we),
    .waddr(IDX_W'(slot)),
    .wdata({note_value, octave_shift, rest_flag, DB'(duration)}),
    .re   (rd_en),
    .raddr(cnt[IDX_W-1:0]),
    .rdata(rdata)
  );

  assign rd_dur = rdata[DB-1:0];
  assign reach  = acc + TOT_W'(rd_dur);

  psg_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  // walk control: one read issued per cycle, data used in the following cycle
  assign walking   = (state == S_SUM) || (state == S_FIND);
  assign walk_done = walking && (cnt == n_live) && !rvalid;
  assign out_free  = !result_valid || !result_stall;
  assign item_take = item_valid && !item_stall;

  // release evaluation of the covering event
  assign ev_rest_fall = !prv_rest && c_rest;
  assign ev_sounding  = (articulation != ART_LEGATO) && !c_rest;
  assign ev_short     = 32'(c_dur) < 32'd2;

  // off sits on floor(span*m/d) when d*off <= span*m < d*off + d; that point
  // is always below span for both fractions
  always_comb begin
    if (articulation == ART_STACCATO) begin
      span_x = MUL_W'(c_dur) * MUL_W'(STAC_MUL);
      rel_lo = MUL_W'(off) * MUL_W'(STAC_DIV);
      rel_hi = rel_lo + MUL_W'(STAC_DIV);
    end else begin
      span_x = MUL_W'(c_dur) * MUL_W'(NORM_MUL);
      rel_lo = MUL_W'(off) * MUL_W'(NORM_DIV);
      rel_hi = rel_lo + MUL_W'(NORM_DIV);
    end
  end

  assign rel_hit = (rel_lo <= span_x) && (span_x < rel_hi);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_take) begin
          state_next = (req_type == REQ_LOAD) ? S_OUT : S_SUM;
        end
      end
      S_SUM: begin
        if (walk_done) begin
          state_next = (acc == '0) ? S_OUT : S_MOD;
        end
      end
      S_MOD: begin
        if (div_done) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (walk_done) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_stall = (state != S_IDLE);
    rd_en      = walking && (cnt != n_live);
    div_start  = 1'b0;
    div_dvd    = DVD_W'(pulse_reg);
    div_dvs    = DVS_W'(acc);
    out_fire   = (state == S_OUT) && out_free;
    unique case (state)
      S_SUM: begin
        div_start = walk_done && (acc != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // walk pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      cnt    <= '0;
    end else begin
      rvalid <= rd_en;
      if (rd_en) begin
        cnt <= cnt + 1'b1;
      end else if (!walking) begin
        cnt <= '0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    ridx <= cnt[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        pulse_reg <= pulse;
        is_load   <= (req_type == REQ_LOAD);
        found     <= 1'b0;
        rise      <= 1'b0;
        fall      <= 1'b0;
        acc       <= '0;
      end
      S_SUM: begin
        if (rvalid) begin
          acc <= reach;
        end
        if (walk_done) begin
          total <= acc;
        end
      end
      S_MOD: begin
        if (div_done) begin
          // previous pulse wraps to the last pulse of the loop
          np      <= TOT_W'(div_rem);
          pp      <= (div_rem == '0) ? total - 1'b1 : TOT_W'(div_rem) - 1'b1;
          acc     <= '0;
          cur_hit <= 1'b0;
          prv_hit <= 1'b0;
        end
      end
      S_FIND: begin
        if (rvalid) begin
          acc <= reach;
          if (!cur_hit && (np < reach)) begin
            cur_hit   <= 1'b1;
            cur_idx   <= ridx;
            off       <= np - acc;
            c_note    <= rdata[NOTE_LO +: NOTE_W];
            c_oct     <= rdata[OCT_LO +: OCT_W];
            c_rest    <= rdata[REST_B];
            c_dur     <= rd_dur;
          end
          if (!prv_hit && (pp < reach)) begin
            prv_hit  <= 1'b1;
            prv_idx  <= ridx;
            prv_rest <= rdata[REST_B];
          end
        end
      end
      S_EVAL: begin
        found <= 1'b1;
        rise  <= (cur_idx != prv_idx);
        fall  <= ev_rest_fall || (ev_sounding && (ev_short || rel_hit));
      end
      default: ;
    endcase
  end

  // gate: a new sounding event sets it, a release clears it and wins
  always_comb begin
    gate_next = gate;
    if (found && !c_rest && rise) begin
      gate_next = 1'b1;
    end
    if (fall) begin
      gate_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        gate         <= gate_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_fire) begin
      event_found <= found;
      event_index <= found ? EVENT_INDEX_W'(cur_idx) : '0;
      cur_note    <= found ? c_note : '0;
      cur_octave  <= found ? signed'(c_oct) : '0;
      cur_rest    <= is_load ? 1'b0 : (found ? c_rest : 1'b1);
      rise_edge   <= rise;
      fall_edge   <= fall;
      gate_level  <= gate_next;
    end
  end

`ifndef SYNTH
  a_fall_clears: assert property (@(posedge clk) disable iff (rst)
      result_valid |-> !(fall_edge && gate_level))
    else $error("gate high on a release beat");
  a_edge_found: assert property (@(posedge clk) disable iff (rst)
      (result_valid && (rise_edge || fall_edge)) |-> event_found)
    else $error("edge reported without an event");
  a_read_range: assert property (@(posedge clk) disable iff (rst)
      rd_en |-> (32'(cnt) < 32'(n_live)))
    else $error("table read beyond live count");
  a_find_total: assert property (@(posedge clk) disable iff (rst)
      (state == S_FIND) |-> (total != '0))
    else $error("event search with empty loop");
`endif

endmodule
